// ===== hdl/nfa_pkg.sv =====
// Shared types and constants for the epsilon-NFA acceptor.
package nfa_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_TR  = 2'd0,
        OP_LOAD_EPS = 2'd1,
        OP_START    = 2'd2,
        OP_SYMBOL   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GATHER,
        ST_CLOSE,
        ST_FINISH
    } ctrl_state_t;

    localparam logic [1:0] REG_INITIAL_STATE = 2'd0;
    localparam logic [1:0] REG_FINAL_MASK    = 2'd1;
    localparam logic [1:0] REG_ALPHABET_SIZE = 2'd2;
    localparam logic [1:0] REG_SYMBOL_BASE   = 2'd3;

    localparam logic [3:0] INITIAL_STATE_RESET = 4'd0;
    localparam logic [15:0] FINAL_MASK_RESET   = 16'd0;
    localparam logic [5:0] ALPHABET_SIZE_RESET = 6'd26;
    localparam logic [7:0] SYMBOL_BASE_RESET   = 8'd97;

    typedef struct packed {
        logic [3:0]  initial_state;
        logic [15:0] final_mask;
        logic [5:0]  alphabet_size;
        logic [7:0]  symbol_base;
    } cfg_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic gather_step;
        logic close_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic gather_done;
        logic close_done;
    } dp_status_t;

endpackage

// ===== hdl/nfa_cfg.sv =====
// APB configuration registers of the epsilon-NFA acceptor.
module nfa_cfg
    import nfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_state <= INITIAL_STATE_RESET;
            cfg_reg.final_mask    <= FINAL_MASK_RESET;
            cfg_reg.alphabet_size <= ALPHABET_SIZE_RESET;
            cfg_reg.symbol_base   <= SYMBOL_BASE_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_INITIAL_STATE: cfg_reg.initial_state <= pwdata[3:0];
                REG_FINAL_MASK:    cfg_reg.final_mask    <= pwdata[15:0];
                REG_ALPHABET_SIZE: cfg_reg.alphabet_size <= pwdata[5:0];
                REG_SYMBOL_BASE:   cfg_reg.symbol_base   <= pwdata[7:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_INITIAL_STATE: prdata = {28'd0, cfg_reg.initial_state};
            REG_FINAL_MASK:    prdata = {16'd0, cfg_reg.final_mask};
            REG_ALPHABET_SIZE: prdata = {26'd0, cfg_reg.alphabet_size};
            REG_SYMBOL_BASE:   prdata = {24'd0, cfg_reg.symbol_base};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/nfa_ctrl.sv =====
// Sequencing state machine of the epsilon-NFA acceptor.
module nfa_ctrl
    import nfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  op_t        in_op,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_op) inside
                        OP_LOAD_TR, OP_LOAD_EPS: state_next = ST_FINISH;
                        OP_START:                state_next = ST_CLOSE;
                        OP_SYMBOL:               state_next = ST_GATHER;
                        default:                 state_next = ST_FINISH;
                    endcase
                end
            end
            ST_GATHER:
            begin
                if (status.gather_done)
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                if (status.close_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        cmd.clear_step  = (state_reg == ST_CLEAR) && !status.clear_done;
        cmd.accept      = (state_reg == ST_IDLE) && in_valid;
        cmd.gather_step = (state_reg == ST_GATHER) && !status.gather_done;
        cmd.close_step  = (state_reg == ST_CLOSE) && !status.close_done;
        cmd.load_out    = (state_reg == ST_FINISH) && slot_free;
    end

endmodule

// ===== hdl/nfa_dp.sv =====
// Datapath of the epsilon-NFA acceptor: row stores, active set and closure unit.
module nfa_dp
    import nfa_pkg::*;
#(
    parameter int MAX_STATES  = 16,
    parameter int MAX_SYMBOLS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  op_t         op,
    input  logic [3:0]  state_index,
    input  logic [7:0]  symbol,
    input  logic [15:0] row_mask,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic [15:0] active_states,
    output logic        accepted,
    output logic        dead
);

    localparam int SW    = MAX_STATES;
    localparam int STW   = $clog2(MAX_STATES);
    localparam int SYW   = $clog2(MAX_SYMBOLS);
    localparam int DEPTH = MAX_STATES * MAX_SYMBOLS;
    localparam int AW    = $clog2(DEPTH);

    typedef logic [SW-1:0] set_t;

    // Transition rows, one per (state, symbol); cleared by a sweep after reset.
    set_t tr_mem [DEPTH];
    set_t eps_reg [MAX_STATES];

    set_t            active_reg;
    set_t            work_reg;
    set_t            rd_data_reg;
    logic            rd_valid_reg;
    logic [STW-1:0]  rd_state_reg;
    logic [STW:0]    cnt_reg;
    logic [AW:0]     gather_addr_reg;
    logic [AW:0]     clr_cnt_reg;
    op_t             op_reg;
    logic            alpha_reg;
    set_t            out_active_reg;
    logic            out_accepted_reg;
    logic            out_dead_reg;

    logic [7:0]      sym_diff;
    logic            in_alpha;
    logic [SYW-1:0]  in_idx;
    logic            st_ok;
    logic [STW-1:0]  st_idx;
    set_t            row_val;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    set_t            mem_wdata;
    set_t            eps_union;
    set_t            close_next;
    set_t            start_set;
    set_t            result;

    assign sym_diff  = symbol - cfg.symbol_base;
    assign in_alpha  = (sym_diff < {2'b00, cfg.alphabet_size}) &&
                       (32'(sym_diff) < MAX_SYMBOLS);
    assign in_idx    = SYW'(sym_diff);
    assign st_ok     = 32'(state_index) < MAX_STATES;
    assign st_idx    = STW'(state_index);
    assign row_val   = SW'(row_mask);
    assign start_set = (32'(cfg.initial_state) < MAX_STATES) ?
                       (SW'(1) << cfg.initial_state) : '0;

    assign mem_we    = cmd.clear_step ||
                       (cmd.accept && (op == OP_LOAD_TR) && st_ok && in_alpha);
    assign mem_waddr = cmd.clear_step ? clr_cnt_reg[AW-1:0] :
                       AW'(32'(st_idx) * MAX_SYMBOLS + 32'(in_idx));
    assign mem_wdata = cmd.clear_step ? '0 : row_val;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tr_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= tr_mem[gather_addr_reg[AW-1:0]];
    end

    // One epsilon pass: every state of the working set contributes its epsilon row.
    always_comb
    begin
        eps_union = '0;
        for (int s = 0; s < MAX_STATES; s++)
        begin
            if (work_reg[s])
            begin
                eps_union = eps_union | eps_reg[s];
            end
        end
    end

    assign close_next = work_reg | eps_union;
    assign result     = ((op_reg == OP_LOAD_TR) || (op_reg == OP_LOAD_EPS)) ?
                        active_reg : work_reg;

    assign status.clear_done  = (clr_cnt_reg == (AW+1)'(DEPTH));
    assign status.gather_done = (cnt_reg == (STW+1)'(MAX_STATES));
    assign status.close_done  = (close_next == work_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_STATES; s++)
            begin
                eps_reg[s] <= '0;
            end
            active_reg      <= '0;
            rd_valid_reg    <= 1'b0;
            cnt_reg         <= '0;
            gather_addr_reg <= '0;
            clr_cnt_reg     <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.gather_step;
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                cnt_reg         <= '0;
                gather_addr_reg <= (AW+1)'(in_idx);
                if ((op == OP_LOAD_EPS) && st_ok)
                begin
                    eps_reg[st_idx] <= row_val;
                end
            end
            else if (cmd.gather_step)
            begin
                cnt_reg         <= cnt_reg + 1'b1;
                gather_addr_reg <= gather_addr_reg + (AW+1)'(MAX_SYMBOLS);
            end
            if (cmd.load_out)
            begin
                active_reg <= result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= op;
            alpha_reg <= in_alpha;
            work_reg  <= (op == OP_START) ? start_set : '0;
        end
        else if (cmd.close_step)
        begin
            work_reg <= close_next;
        end
        else if (rd_valid_reg && alpha_reg && active_reg[rd_state_reg])
        begin
            work_reg <= work_reg | rd_data_reg;
        end
        if (cmd.gather_step)
        begin
            rd_state_reg <= cnt_reg[STW-1:0];
        end
        if (cmd.load_out)
        begin
            out_active_reg   <= result;
            out_accepted_reg <= |(result & SW'(cfg.final_mask));
            out_dead_reg     <= (result == '0);
        end
    end

    assign active_states = 16'(out_active_reg);
    assign accepted      = out_accepted_reg;
    assign dead          = out_dead_reg;

endmodule

// ===== hdl/nfa_epsilon_acceptor_top.sv =====
// Top level of the epsilon-NFA acceptor: configuration port, controller and datapath.
//
// The block tracks the active state set of an automaton with epsilon moves and
// returns one result beat for every input beat. After reset it first clears the
// transition store, one row per cycle, all MAX_STATES*MAX_SYMBOLS rows (512 at
// the default sizes), and accepts no input beat until that is done; register
// writes are taken at any time. One item is worked on at a time. A row load goes
// straight to the result stage. A symbol item reads one transition row per state
// through the single read port of the transition store, then runs epsilon
// closure passes until a pass adds no state; a start item runs only the closure
// passes. The result register lets a new item start while a result waits.
module nfa_epsilon_acceptor_top
    import nfa_pkg::*;
#(
    parameter int MAX_STATES  = 16,
    parameter int MAX_SYMBOLS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [3:0]  state_index,
    input  logic [7:0]  symbol,
    input  logic [15:0] row_mask,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] active_states,
    output logic        accepted,
    output logic        dead
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;
    op_t        in_op;

    assign in_op = op_t'(op);

    nfa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (in_op),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    nfa_dp #(
        .MAX_STATES  (MAX_STATES),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .op            (in_op),
        .state_index   (state_index),
        .symbol        (symbol),
        .row_mask      (row_mask),
        .cmd           (cmd),
        .status        (status),
        .active_states (active_states),
        .accepted      (accepted),
        .dead          (dead)
    );

endmodule

// ===== sim/nfa_epsilon_acceptor_top_test.sv =====
// Self-checking testbench for the epsilon-NFA acceptor: directed and random beats, APB setup.
`timescale 1ns / 1ps

module nfa_epsilon_acceptor_top_test
    import nfa_pkg::*;
();

    typedef struct {
        op_t         op;
        logic [3:0]  src;
        logic [7:0]  sym;
        logic [15:0] mask;
    } nfa_item_t;

    typedef struct {
        logic [15:0] states;
        logic        acc;
        logic        empty;
    } nfa_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = 2'd0;
    logic [3:0]  state_index = 4'd0;
    logic [7:0]  symbol = 8'd0;
    logic [15:0] row_mask = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] active_states;
    logic        accepted;
    logic        dead;

    // Shadow copy of the automaton that the predictor works on.
    logic [15:0] tr_rows [0:15][0:31];
    logic [15:0] eps_rows [0:15];
    logic [15:0] live_set;
    cfg_t        cfg;

    nfa_item_t   pending_items[$];
    nfa_result_t expected_sets[$];
    nfa_item_t   cur_item;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_input = 1'b0;
    int  errors = 0;
    int  beats_checked = 0;
    int  op_count[4] = '{0, 0, 0, 0};
    int  settings_used = 0;

    nfa_epsilon_acceptor_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .state_index(state_index),
        .symbol(symbol),
        .row_mask(row_mask),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .active_states(active_states),
        .accepted(accepted),
        .dead(dead)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] eps_closure(input logic [15:0] seed);
        logic [15:0] grown;
        for (int pass = 0; pass <= 16; pass++)
        begin
            grown = seed;
            for (int k = 0; k < 16; k++)
                if (seed[k])
                    grown |= eps_rows[k];
            if (grown == seed)
                break;
            seed = grown;
        end
        return seed;
    endfunction

    function automatic bit symbol_index(input logic [7:0] b, output logic [4:0] idx);
        logic [7:0] d;
        d = b - cfg.symbol_base;
        idx = d[4:0];
        return (d < cfg.alphabet_size) && (d < 8'd32);
    endfunction

    function automatic nfa_result_t apply_item(input nfa_item_t it);
        nfa_result_t r;
        logic [4:0]  idx;
        logic [15:0] gathered;
        case (it.op)
            OP_LOAD_TR:
                if (symbol_index(it.sym, idx))
                    tr_rows[it.src][idx] = it.mask;
            OP_LOAD_EPS:
                eps_rows[it.src] = it.mask;
            OP_START:
                live_set = eps_closure(16'd1 << cfg.initial_state);
            default:
            begin
                gathered = 16'd0;
                if (symbol_index(it.sym, idx))
                begin
                    for (int k = 0; k < 16; k++)
                        if (live_set[k])
                            gathered |= tr_rows[k][idx];
                    live_set = eps_closure(gathered);
                end
                else
                    live_set = 16'd0;
            end
        endcase
        r.states = live_set;
        r.acc = |(live_set & cfg.final_mask);
        r.empty = (live_set == 16'd0);
        return r;
    endfunction

    // Input side: present the next pending beat, or idle at random.
    always @(posedge clk)
    begin : feed
        nfa_item_t nxt;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_sets.push_back(apply_item(cur_item));
                op_count[cur_item.op]++;
            end
            if (!in_valid || in_ready)
            begin
                if (!hold_input && pending_items.size() > 0 &&
                    $urandom_range(99, 0) >= send_idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    cur_item <= nxt;
                    in_valid <= 1'b1;
                    op <= nxt.op;
                    state_index <= nxt.src;
                    symbol <= nxt.sym;
                    row_mask <= nxt.mask;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output side: random backpressure and a field-by-field compare.
    always @(posedge clk)
    begin : observe
        nfa_result_t want;
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            if (out_valid && out_ready)
            begin
                if (expected_sets.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got %h", $time,
                             active_states);
                    errors++;
                end
                else
                begin
                    want = expected_sets.pop_front();
                    beats_checked++;
                    if (active_states !== want.states)
                    begin
                        $display("%0t: active_states expected %h got %h", $time,
                                 want.states, active_states);
                        errors++;
                    end
                    if (accepted !== want.acc)
                    begin
                        $display("%0t: accepted expected %b got %b", $time, want.acc,
                                 accepted);
                        errors++;
                    end
                    if (dead !== want.empty)
                    begin
                        $display("%0t: dead expected %b got %b", $time, want.empty, dead);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_item(input op_t o, input logic [3:0] s, input logic [7:0] y,
                             input logic [15:0] m);
        nfa_item_t it;
        it.op = o;
        it.src = s;
        it.sym = y;
        it.mask = m;
        pending_items.push_back(it);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_INITIAL_STATE: cfg.initial_state = val[3:0];
            REG_FINAL_MASK:    cfg.final_mask = val[15:0];
            REG_ALPHABET_SIZE: cfg.alphabet_size = val[5:0];
            default:           cfg.symbol_base = val[7:0];
        endcase
    endtask

    task automatic set_config(input logic [3:0] init, input logic [15:0] fin,
                              input logic [5:0] alpha, input logic [7:0] base);
        write_reg(REG_INITIAL_STATE, {28'd0, init});
        write_reg(REG_FINAL_MASK, {16'd0, fin});
        write_reg(REG_ALPHABET_SIZE, {26'd0, alpha});
        write_reg(REG_SYMBOL_BASE, {24'd0, base});
        settings_used++;
    endtask

    // Every result beat is one-for-one, so idle means nothing queued or in flight.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() > 0 || in_valid || expected_sets.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [7:0] in_alphabet_byte();
        return cfg.symbol_base + 8'($urandom_range(int'(cfg.alphabet_size) - 1, 0));
    endfunction

    function automatic logic [15:0] sparse_mask();
        case ($urandom_range(4, 0))
            0: return 16'd0;
            1: return 16'd1 << $urandom_range(15, 0);
            2: return (16'd1 << $urandom_range(15, 0)) | (16'd1 << $urandom_range(15, 0));
            3: return 16'($urandom & $urandom);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly whole runs: a few row loads, a start, then a string of symbols.
    task automatic gen_runs(input int count);
        int made;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(9, 0) == 0)
            begin
                push_item(op_t'($urandom_range(3, 0)), 4'($urandom), 8'($urandom),
                          16'($urandom));
                made++;
            end
            else
            begin
                repeat ($urandom_range(8, 1))
                begin
                    if ($urandom_range(3, 0) == 0)
                        push_item(OP_LOAD_EPS, 4'($urandom), 8'($urandom), sparse_mask());
                    else if ($urandom_range(7, 0) == 0)
                        push_item(OP_LOAD_TR, 4'($urandom), 8'($urandom), sparse_mask());
                    else
                        push_item(OP_LOAD_TR, 4'($urandom), in_alphabet_byte(),
                                  sparse_mask());
                    made++;
                end
                push_item(OP_START, 4'($urandom), 8'($urandom), 16'($urandom));
                made++;
                repeat ($urandom_range(12, 2))
                begin
                    if ($urandom_range(9, 0) == 0)
                        push_item(OP_SYMBOL, 4'($urandom), 8'($urandom), 16'($urandom));
                    else
                        push_item(OP_SYMBOL, 4'($urandom), in_alphabet_byte(),
                                  16'($urandom));
                    made++;
                end
            end
        end
    endtask

    initial
    begin
        for (int s = 0; s < 16; s++)
        begin
            eps_rows[s] = 16'd0;
            for (int y = 0; y < 32; y++)
                tr_rows[s][y] = 16'd0;
        end
        live_set = 16'd0;
        cfg.initial_state = INITIAL_STATE_RESET;
        cfg.final_mask = FINAL_MASK_RESET;
        cfg.alphabet_size = ALPHABET_SIZE_RESET;
        cfg.symbol_base = SYMBOL_BASE_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 78;
        set_config(4'd15, 16'h0001, 6'd26, 8'd97);

        // Directed: empty start, an epsilon chain that runs downward through the
        // state order, loads outside the alphabet, and bytes on both sides of it.
        push_item(OP_SYMBOL, 4'd0, 8'd97, 16'h0000);
        push_item(OP_START, 4'd0, 8'd0, 16'h0000);
        push_item(OP_LOAD_EPS, 4'd15, 8'd0, 16'h0400);
        push_item(OP_LOAD_EPS, 4'd10, 8'd255, 16'h0020);
        push_item(OP_LOAD_EPS, 4'd5, 8'd0, 16'h0001);
        push_item(OP_LOAD_EPS, 4'd0, 8'd0, 16'h0000);
        push_item(OP_START, 4'd15, 8'd255, 16'hFFFF);
        push_item(OP_LOAD_TR, 4'd0, 8'd97, 16'hFFFF);
        push_item(OP_LOAD_TR, 4'd15, 8'd122, 16'h8000);
        push_item(OP_LOAD_TR, 4'd3, 8'd123, 16'h1234);
        push_item(OP_LOAD_TR, 4'd0, 8'd96, 16'h0F0F);
        push_item(OP_SYMBOL, 4'd0, 8'd97, 16'h0000);
        push_item(OP_SYMBOL, 4'd15, 8'd122, 16'hFFFF);
        push_item(OP_SYMBOL, 4'd0, 8'd123, 16'h0000);
        push_item(OP_SYMBOL, 4'd0, 8'd96, 16'h0000);
        push_item(OP_START, 4'd0, 8'd0, 16'h0000);
        push_item(OP_SYMBOL, 4'd0, 8'd0, 16'h0000);
        push_item(OP_START, 4'd0, 8'd0, 16'h0000);
        push_item(OP_SYMBOL, 4'd0, 8'd255, 16'h0000);
        push_item(OP_LOAD_EPS, 4'd0, 8'd0, 16'hFFFF);
        push_item(OP_START, 4'd0, 8'd0, 16'h0000);
        push_item(OP_SYMBOL, 4'd15, 8'd98, 16'h0000);
        push_item(OP_LOAD_EPS, 4'd0, 8'd0, 16'h0000);
        gen_runs(270);
        wait_drained();

        // Narrowest alphabet at the top byte; every state accepting.
        set_config(4'd0, 16'hFFFF, 6'd1, 8'd255);
        gen_runs(270);
        @(negedge clk);
        while (pending_items.size() > 135)
            @(negedge clk);
        hold_input = 1'b1;
        while (in_valid || expected_sets.size() > 0)
            @(negedge clk);
        hold_input = 1'b0;
        wait_drained();

        send_idle_pct = 78;
        recv_idle_pct = 34;
        set_config(4'd7, 16'h8421, 6'd32, 8'd0);
        gen_runs(270);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(4'($urandom), 16'($urandom), 6'($urandom_range(32, 1)), 8'($urandom));
        gen_runs(270);
        wait_drained();
        repeat (40) @(posedge clk);

        $display("Covered %0d row loads, %0d epsilon loads, %0d starts, %0d symbol steps",
                 op_count[OP_LOAD_TR], op_count[OP_LOAD_EPS], op_count[OP_START],
                 op_count[OP_SYMBOL]);
        $display("under %0d register settings; %0d result beats compared.", settings_used,
                 beats_checked);
        if (expected_sets.size() > 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_sets.size());
            errors++;
        end
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timed out with %0d beats pending, %0d results outstanding", $time,
                 pending_items.size(), expected_sets.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
